// File: sv/assert_macros.svh
// Assertion macros shared by the fixed-step tick scheduler RTL.
// Each macro expands to one labeled concurrent assertion on a given clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Plain property check, disabled while reset is high.
`define FSTS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Same-cycle implication check.
`define FSTS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`endif

// File: sv/fsts_pkg.sv
// Package for the fixed-step tick scheduler: payload structs, control structs and constants.
// No dependencies.
`default_nettype none
package fsts_pkg;

   localparam int unsigned DELTA_W = 36;
   localparam int unsigned ACC_W   = 37;
   localparam int unsigned MCU_W   = 7;
   localparam int unsigned ORIG_W  = 62;
   localparam int unsigned CSR_W   = 62;
   localparam int unsigned ADDR_W  = 3;
   localparam int unsigned DIV_CNT_W = 6;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = 6'(ACC_W - 1);

   localparam logic [DELTA_W-1:0] MAX_DELTA_NS = 36'd60000000000;

   localparam logic [DELTA_W-1:0] STEP_RESET  = 36'd16666667;
   localparam logic [DELTA_W-1:0] FRAME_RESET = 36'd250000000;
   localparam logic [DELTA_W-1:0] HARD_RESET  = 36'd1000000000;
   localparam logic [MCU_W-1:0]   MCU_RESET   = 7'd8;
   localparam logic [ORIG_W-1:0]  ORIG_RESET  = 62'd0;

   localparam logic [ADDR_W-1:0] REG_STEP   = 3'd0;
   localparam logic [ADDR_W-1:0] REG_FRAME  = 3'd1;
   localparam logic [ADDR_W-1:0] REG_HARD   = 3'd2;
   localparam logic [ADDR_W-1:0] REG_MCU    = 3'd3;
   localparam logic [ADDR_W-1:0] REG_ORIGIN = 3'd4;

   localparam logic [2:0] ST_TICK    = 3'd0;
   localparam logic [2:0] ST_NOTICK  = 3'd1;
   localparam logic [2:0] ST_FOCUS   = 3'd2;
   localparam logic [2:0] ST_INVALID = 3'd3;
   localparam logic [2:0] ST_UNCONF  = 3'd4;
   localparam logic [2:0] ST_RESTART = 3'd5;
   localparam logic [2:0] ST_REJECT  = 3'd6;

   typedef struct packed {
      logic                req_type;
      logic [DELTA_W-1:0]  elapsed_ns;
      logic                focused;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]          status;
      logic                last;
      logic [63:0]         tick_number;
      logic [63:0]         tick_time_ns;
      logic [MCU_W-1:0]    ticks_this_sample;
      logic [ACC_W-1:0]    accumulator_ns;
      logic [63:0]         dropped_ns;
      logic [31:0]         invalid_count;
      logic [31:0]         capped_count;
      logic [31:0]         catch_up_limit_count;
      logic [31:0]         focus_reset_count;
      logic [MCU_W-1:0]    max_ticks_seen;
   } rsp_payload_type;

   typedef struct packed {
      logic load;
      logic classify;
      logic div_step;
      logic eval;
      logic check;
      logic update;
      logic emit_single;
      logic emit_tick;
   } ctrl_cmd_type;

   typedef struct packed {
      logic work;
      logic div_done;
      logic last_tick;
      logic out_free;
   } ctrl_stat_type;

endpackage
`default_nettype wire

// File: sv/fsts_ctrl.sv
// Controller state machine of the fixed-step tick scheduler.
// Depends on fsts_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module fsts_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  fsts_pkg::ctrl_stat_type  stat,
   output fsts_pkg::ctrl_cmd_type   cmd
);
   import fsts_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CLASS = 4'd1;
   localparam logic [3:0] S_ROUTE = 4'd2;
   localparam logic [3:0] S_DIV   = 4'd3;
   localparam logic [3:0] S_EVAL  = 4'd4;
   localparam logic [3:0] S_CHECK = 4'd5;
   localparam logic [3:0] S_UPD   = 4'd6;
   localparam logic [3:0] S_OUT   = 4'd7;
   localparam logic [3:0] S_TICK  = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CLASS;
            end
         end
         S_CLASS: begin
            cmd.classify = 1'b1;
            state_in     = S_ROUTE;
         end
         S_ROUTE: begin
            state_in = stat.work ? S_DIV : S_UPD;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) state_in = S_EVAL;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = S_UPD;
         end
         S_UPD: begin
            cmd.update = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (stat.work) begin
               state_in = S_TICK;
            end else if (stat.out_free) begin
               cmd.emit_single = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_TICK: begin
            if (stat.out_free) begin
               cmd.emit_tick = 1'b1;
               if (stat.last_tick) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `FSTS_ASSERT(a_div_exit, clock, reset, (state_ff == S_DIV) |=> (state_ff == S_DIV || state_ff == S_EVAL), "divider left to wrong state")
   `FSTS_ASSERT_IMPL(a_last_tick_idle, clock, reset, $past(cmd.emit_tick && stat.last_tick), state_ff == S_IDLE, "last tick did not end the sample")

endmodule
`default_nettype wire

// File: sv/fsts_dp.sv
// Datapath of the fixed-step tick scheduler: registers, state, bit-serial divider and result register.
// Depends on fsts_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module fsts_dp #(
   parameter int unsigned CATCH_UP_LIMIT = 64
) (
   input  wire                                clock,
   input  wire                                reset,
   input  fsts_pkg::ctrl_cmd_type             cmd,
   output fsts_pkg::ctrl_stat_type            stat,
   input  fsts_pkg::req_payload_type          req_data,
   input  wire                                csr_wr_en,
   input  wire  [fsts_pkg::ADDR_W-1:0]        csr_addr,
   input  wire  [fsts_pkg::CSR_W-1:0]         csr_wr_data,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output fsts_pkg::rsp_payload_type          rsp_data
);
   import fsts_pkg::*;

   // Configuration registers and the copy in force.
   logic [DELTA_W-1:0] step_reg_ff, step_reg_in, frame_reg_ff, frame_reg_in;
   logic [DELTA_W-1:0] hard_reg_ff, hard_reg_in;
   logic [MCU_W-1:0]   mcu_reg_ff, mcu_reg_in;
   logic [ORIG_W-1:0]  origin_reg_ff, origin_reg_in;
   logic [DELTA_W-1:0] act_step_ff, act_step_in, act_frame_ff, act_frame_in;
   logic [DELTA_W-1:0] act_hard_ff, act_hard_in;
   logic [MCU_W-1:0]   act_mcu_ff, act_mcu_in;

   // Scheduler state.
   logic               configured_ff, configured_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [63:0]        tc_ff, tc_in, prod_ff, prod_in, dropped_ff, dropped_in;
   logic [64:0]        tsum_ff, tsum_in;
   logic [31:0]        invalid_ff, invalid_in, capped_ff, capped_in;
   logic [31:0]        limit_ff, limit_in, focus_ff, focus_in;
   logic [MCU_W-1:0]   max_ticks_ff, max_ticks_in;

   // Per-sample work registers.
   req_payload_type    in_ff, in_in;
   logic [2:0]         cls_ff, cls_in;
   logic               capflag_ff, capflag_in, limflag_ff, limflag_in;
   logic [DELTA_W-1:0] excess_ff, excess_in;
   logic [ACC_W-1:0]   acc_sum_ff, acc_sum_in, rem_ff, rem_in, quo_ff, quo_in;
   logic [ACC_W-1:0]   disc_ff, disc_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [MCU_W-1:0]   n_ff, n_in, k_ff, k_in;
   logic [42:0]        nstep_ff, nstep_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;

   logic               cfg_ok, sample_bad, out_free;
   logic [DELTA_W-1:0] admitted;
   logic [ACC_W-1:0]   trial, diff;
   logic [64:0]        tc_sum, prod_sum, tsum_next;
   logic [65:0]        drop_sum;
   logic [MCU_W-1:0]   n_sel;

   function automatic logic in_range(input logic [DELTA_W-1:0] v);
      return (v != '0) && (v <= MAX_DELTA_NS);
   endfunction

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
   endfunction

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cfg_ok = in_range(step_reg_ff) && in_range(frame_reg_ff) && in_range(hard_reg_ff)
               && (mcu_reg_ff != '0) && (32'(mcu_reg_ff) <= 32'(CATCH_UP_LIMIT))
               && (frame_reg_ff >= step_reg_ff) && (hard_reg_ff >= frame_reg_ff);
      sample_bad = (in_ff.elapsed_ns == '0) || (in_ff.elapsed_ns > MAX_DELTA_NS)
                   || (in_ff.elapsed_ns > act_hard_ff);
      admitted = (in_ff.elapsed_ns > act_frame_ff) ? act_frame_ff : in_ff.elapsed_ns;
      trial = {rem_ff[ACC_W-2:0], quo_ff[ACC_W-1]};
      diff  = trial - {1'b0, act_step_ff};
      n_sel = (quo_ff > ACC_W'(act_mcu_ff)) ? act_mcu_ff : quo_ff[MCU_W-1:0];
      tc_sum   = {1'b0, tc_ff} + 65'(n_ff);
      prod_sum = {1'b0, prod_ff} + 65'(nstep_ff);
      tsum_next = tsum_ff + 65'(act_step_ff);
      if (cls_ff == ST_FOCUS) begin
         drop_sum = 66'(dropped_ff) + 66'(acc_ff) + 66'(in_ff.elapsed_ns);
      end else begin
         drop_sum = 66'(dropped_ff) + 66'(excess_ff) + 66'(disc_ff);
      end
   end

   always_comb begin
      step_reg_in = step_reg_ff; frame_reg_in = frame_reg_ff; hard_reg_in = hard_reg_ff;
      mcu_reg_in = mcu_reg_ff; origin_reg_in = origin_reg_ff;
      act_step_in = act_step_ff; act_frame_in = act_frame_ff; act_hard_in = act_hard_ff;
      act_mcu_in = act_mcu_ff;
      configured_in = configured_ff; acc_in = acc_ff; tc_in = tc_ff; prod_in = prod_ff;
      tsum_in = tsum_ff; dropped_in = dropped_ff; invalid_in = invalid_ff;
      capped_in = capped_ff; limit_in = limit_ff; focus_in = focus_ff;
      max_ticks_in = max_ticks_ff;
      in_in = in_ff; cls_in = cls_ff; capflag_in = capflag_ff; limflag_in = limflag_ff;
      excess_in = excess_ff; acc_sum_in = acc_sum_ff; rem_in = rem_ff; quo_in = quo_ff;
      disc_in = disc_ff; div_cnt_in = div_cnt_ff; n_in = n_ff; k_in = k_ff;
      nstep_in = nstep_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;

      if (csr_wr_en) begin
         case (csr_addr)
            REG_STEP:   step_reg_in   = csr_wr_data[DELTA_W-1:0];
            REG_FRAME:  frame_reg_in  = csr_wr_data[DELTA_W-1:0];
            REG_HARD:   hard_reg_in   = csr_wr_data[DELTA_W-1:0];
            REG_MCU:    mcu_reg_in    = csr_wr_data[MCU_W-1:0];
            REG_ORIGIN: origin_reg_in = csr_wr_data[ORIG_W-1:0];
            default: ;
         endcase
      end

      if (cmd.load) in_in = req_data;

      if (cmd.classify) begin
         if (in_ff.req_type) begin
            cls_in = cfg_ok ? ST_RESTART : ST_REJECT;
         end else if (!configured_ff) begin
            cls_in = ST_UNCONF;
         end else if (sample_bad) begin
            cls_in = ST_INVALID;
         end else if (!in_ff.focused) begin
            cls_in = ST_FOCUS;
         end else begin
            cls_in = ST_TICK;
         end
         capflag_in = in_ff.elapsed_ns > act_frame_ff;
         excess_in  = capflag_in ? in_ff.elapsed_ns - act_frame_ff : '0;
         acc_sum_in = acc_ff + ACC_W'(admitted);
         quo_in     = acc_sum_in;
         rem_in     = '0;
         div_cnt_in = '0;
      end

      if (cmd.div_step) begin
         if (trial >= {1'b0, act_step_ff}) begin
            rem_in = diff;
            quo_in = {quo_ff[ACC_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[ACC_W-2:0], 1'b0};
         end
         div_cnt_in = div_cnt_ff + 6'd1;
      end

      if (cmd.eval) begin
         n_in       = n_sel;
         nstep_in   = 43'(n_sel) * 43'(act_step_ff);
         limflag_in = quo_ff > ACC_W'(act_mcu_ff);
         k_in       = '0;
      end

      if (cmd.check) begin
         disc_in = acc_sum_ff - rem_ff - nstep_ff[ACC_W-1:0];
         if (tc_sum[64] || prod_sum[64]) begin
            cls_in = ST_INVALID;
         end else if (n_ff == '0) begin
            cls_in = ST_NOTICK;
         end else begin
            cls_in = ST_TICK;
         end
      end

      if (cmd.update) begin
         case (cls_ff)
            ST_RESTART: begin
               act_step_in = step_reg_ff; act_frame_in = frame_reg_ff;
               act_hard_in = hard_reg_ff; act_mcu_in = mcu_reg_ff;
               configured_in = 1'b1;
               acc_in = '0; tc_in = '0; prod_in = '0; tsum_in = 65'(origin_reg_ff);
               dropped_in = '0; invalid_in = '0; capped_in = '0; limit_in = '0;
               focus_in = '0; max_ticks_in = '0;
            end
            ST_FOCUS: begin
               dropped_in = (drop_sum[65:64] != 2'b00) ? '1 : drop_sum[63:0];
               acc_in     = '0;
               focus_in   = sat_inc(focus_ff);
            end
            ST_INVALID: begin
               invalid_in = sat_inc(invalid_ff);
            end
            ST_TICK, ST_NOTICK: begin
               acc_in     = rem_ff;
               dropped_in = (drop_sum[65:64] != 2'b00) ? '1 : drop_sum[63:0];
               if (capflag_ff) capped_in = sat_inc(capped_ff);
               if (limflag_ff) limit_in = sat_inc(limit_ff);
               if (n_ff > max_ticks_ff) max_ticks_in = n_ff;
            end
            default: ;
         endcase
      end

      if (cmd.emit_single || cmd.emit_tick) begin
         rsp_valid_in = 1'b1;
         rsp_data_in.status               = cls_ff;
         rsp_data_in.last                 = 1'b1;
         rsp_data_in.tick_number          = tc_ff;
         rsp_data_in.tick_time_ns         = '0;
         rsp_data_in.ticks_this_sample    = '0;
         rsp_data_in.accumulator_ns       = acc_ff;
         rsp_data_in.dropped_ns           = dropped_ff;
         rsp_data_in.invalid_count        = invalid_ff;
         rsp_data_in.capped_count         = capped_ff;
         rsp_data_in.catch_up_limit_count = limit_ff;
         rsp_data_in.focus_reset_count    = focus_ff;
         rsp_data_in.max_ticks_seen       = max_ticks_ff;
      end

      if (cmd.emit_tick) begin
         tc_in   = tc_ff + 64'd1;
         prod_in = prod_ff + 64'(act_step_ff);
         tsum_in = tsum_next;
         k_in    = k_ff + 7'd1;
         rsp_data_in.status            = ST_TICK;
         rsp_data_in.last              = stat.last_tick;
         rsp_data_in.tick_number       = tc_in;
         rsp_data_in.tick_time_ns      = tsum_next[64] ? '1 : tsum_next[63:0];
         rsp_data_in.ticks_this_sample = n_ff;
      end
   end

   always_comb begin
      stat.work      = (cls_ff == ST_TICK);
      stat.div_done  = (div_cnt_ff == DIV_LAST);
      stat.last_tick = ((k_ff + 7'd1) == n_ff);
      stat.out_free  = out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_reg_ff <= STEP_RESET; frame_reg_ff <= FRAME_RESET; hard_reg_ff <= HARD_RESET;
         mcu_reg_ff <= MCU_RESET; origin_reg_ff <= ORIG_RESET;
         act_step_ff <= STEP_RESET; act_frame_ff <= FRAME_RESET; act_hard_ff <= HARD_RESET;
         act_mcu_ff <= MCU_RESET;
         configured_ff <= 1'b0; acc_ff <= '0; tc_ff <= '0; prod_ff <= '0;
         tsum_ff <= 65'(ORIG_RESET); dropped_ff <= '0; invalid_ff <= '0; capped_ff <= '0;
         limit_ff <= '0; focus_ff <= '0; max_ticks_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_reg_ff <= step_reg_in; frame_reg_ff <= frame_reg_in; hard_reg_ff <= hard_reg_in;
         mcu_reg_ff <= mcu_reg_in; origin_reg_ff <= origin_reg_in;
         act_step_ff <= act_step_in; act_frame_ff <= act_frame_in; act_hard_ff <= act_hard_in;
         act_mcu_ff <= act_mcu_in;
         configured_ff <= configured_in; acc_ff <= acc_in; tc_ff <= tc_in; prod_ff <= prod_in;
         tsum_ff <= tsum_in; dropped_ff <= dropped_in; invalid_ff <= invalid_in;
         capped_ff <= capped_in; limit_ff <= limit_in; focus_ff <= focus_in;
         max_ticks_ff <= max_ticks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff <= in_in; cls_ff <= cls_in; capflag_ff <= capflag_in; limflag_ff <= limflag_in;
      excess_ff <= excess_in; acc_sum_ff <= acc_sum_in; rem_ff <= rem_in; quo_ff <= quo_in;
      disc_ff <= disc_in; div_cnt_ff <= div_cnt_in; n_ff <= n_in; k_ff <= k_in;
      nstep_ff <= nstep_in; rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `FSTS_ASSERT_IMPL(a_emit_slot, clock, reset, cmd.emit_single || cmd.emit_tick, out_free, "result beat overwritten")
   `FSTS_ASSERT_IMPL(a_acc_below_step, clock, reset, configured_ff, acc_ff < {1'b0, act_step_ff}, "accumulator holds a whole step")
   `FSTS_ASSERT_IMPL(a_tick_count, clock, reset, cmd.emit_tick, n_ff != '0 && k_ff < n_ff, "tick emitted beyond sample count")

endmodule
`default_nettype wire

// File: sv/fixed_step_tick_scheduler.sv
// Top level of the fixed-step tick scheduler: controller and datapath.
// Depends on fsts_pkg, fsts_ctrl and fsts_dp.
//
// Frame samples and restarts enter on the req channel; each one yields one result beat, or
// one beat per emitted tick, on the rsp channel. One item at a time is worked on: a restart or
// a rejected, unconfigured, invalid or unfocused sample skips the divider; a focused sample
// runs the divider and then yields one beat per tick (up to the catch-up register value), or
// a single beat if it has no tick or its counters would overflow. The bit-serial divider
// retires one quotient bit per cycle over 37 bits, and the result register sends one tick
// per cycle while rsp_ready is high. Configuration registers may be written whenever the
// block is idle and take effect at the next restart.
`default_nettype none
module fixed_step_tick_scheduler #(
   parameter int unsigned CATCH_UP_LIMIT = 64
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  fsts_pkg::req_payload_type    req_data,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output fsts_pkg::rsp_payload_type    rsp_data,
   input  wire                          csr_wr_en,
   input  wire  [fsts_pkg::ADDR_W-1:0]  csr_addr,
   input  wire  [fsts_pkg::CSR_W-1:0]   csr_wr_data
);
   import fsts_pkg::*;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   fsts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fsts_dp #(
      .CATCH_UP_LIMIT (CATCH_UP_LIMIT)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule
`default_nettype wire
